// File: hw/rtl/cayley_table_property_check_assert.svh
// Assertion macros used by ctpc_checker.sv.
`ifndef CAYLEY_TABLE_PROPERTY_CHECK_ASSERT_SVH
`define CAYLEY_TABLE_PROPERTY_CHECK_ASSERT_SVH
// Antecedent implies consequent in the same cycle.
`define CTPC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define CTPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/ctpc_pkg.sv
package ctpc_pkg;
    // Largest order the table store holds. Entries and element indexes are four bits wide.
    localparam int MAX_ORDER = 16;
    localparam int IW = 4;
    localparam int AW = 2 * IW;
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam logic [4:0] ORDER_RESET = 5'd16;

    typedef logic [IW-1:0]        elem_t;
    typedef logic [AW-1:0]        addr_t;
    typedef logic [MAX_ORDER-1:0] mask_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_AB_RD,
        ST_AS_RD1,
        ST_AS_RD2,
        ST_AS_CHK,
        ST_DONE
    } ctpc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_load;
        logic store_entry;
        logic clear_eval;
        logic scan_read;
        logic scan_check;
        logic ab_read;
        logic assoc_read1;
        logic assoc_read2;
        logic assoc_check;
        logic load_result;
    } ctpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic load_last;
        logic scan_last;
        logic c_last;
        logic assoc_last;
        logic assoc_skip;
    } ctpc_sts_t;
endpackage

// File: hw/rtl/ctpc_ctrl.sv
module ctpc_ctrl
    import ctpc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_write,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      res_free,
    input  ctpc_sts_t sts,
    output ctpc_cmd_t cmd
);
    ctpc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_write) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.store_entry = 1'b1;
                    if (sts.load_last) begin
                        cmd.clear_eval = 1'b1;
                        state_next     = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                cmd.scan_read = 1'b1;
                state_next    = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                cmd.scan_check = 1'b1;
                if (sts.scan_last) begin
                    state_next = sts.assoc_skip ? ST_DONE : ST_AB_RD;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_AB_RD: begin
                cmd.ab_read = 1'b1;
                state_next  = ST_AS_RD1;
            end
            ST_AS_RD1: begin
                cmd.assoc_read1 = 1'b1;
                state_next      = ST_AS_RD2;
            end
            ST_AS_RD2: begin
                cmd.assoc_read2 = 1'b1;
                state_next      = ST_AS_CHK;
            end
            ST_AS_CHK: begin
                cmd.assoc_check = 1'b1;
                if (sts.assoc_last) begin
                    state_next = ST_DONE;
                end else if (sts.c_last) begin
                    state_next = ST_AB_RD;
                end else begin
                    state_next = ST_AS_RD1;
                end
            end
            ST_DONE: begin
                if (res_free) begin
                    cmd.load_result = 1'b1;
                    cmd.clear_load  = 1'b1;
                    state_next      = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end
endmodule

// File: hw/rtl/ctpc_dp.sv
module ctpc_dp
    import ctpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_write,
    input  logic [4:0] cfg_order,
    input  logic [3:0] entry,
    input  ctpc_cmd_t  cmd,
    output ctpc_sts_t  sts,
    output logic [8:0] flags
);
    logic [3:0] table_mem [DEPTH];

    logic [4:0] order_reg;
    logic [4:0] n;
    elem_t      nm1;
    logic       entry_bad;
    always_comb begin
        if (order_reg == 5'd0) begin
            n = 5'd1;
        end else if (order_reg > 5'(MAX_ORDER)) begin
            n = 5'(MAX_ORDER);
        end else begin
            n = order_reg;
        end
        nm1       = IW'(n - 5'd1);
        entry_bad = {1'b0, entry} >= n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RESET;
        end else if (cfg_write) begin
            order_reg <= cfg_order;
        end
    end

    // Load position as row and column.
    elem_t lr_reg, lc_reg;
    logic  bad_reg;
    logic  load_last;
    assign load_last = (lr_reg == nm1) && (lc_reg == nm1);

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_write || cmd.clear_load) begin
            lr_reg  <= '0;
            lc_reg  <= '0;
            bad_reg <= 1'b0;
        end else if (cmd.store_entry) begin
            if (lc_reg == nm1) begin
                lc_reg <= '0;
                lr_reg <= load_last ? '0 : lr_reg + IW'(1);
            end else begin
                lc_reg <= lc_reg + IW'(1);
            end
            if (entry_bad) begin
                bad_reg <= 1'b1;
            end
        end
    end

    // Scan counters and read data.
    elem_t a_reg, b_reg, c_reg;
    elem_t rd0_reg, rd1_reg, ab_reg;
    addr_t addr0, addr1;
    logic  rd0_en, rd1_en;
    logic  a_last, b_last, c_last;
    assign a_last = a_reg == nm1;
    assign b_last = b_reg == nm1;
    assign c_last = c_reg == nm1;

    // Two read addresses a cycle. The scan reads (a,b) and (b,a); the associativity pass
    // reads (a,b), then (b,c) with (a*b,c), then (a,b*c).
    always_comb begin
        addr0  = {a_reg, b_reg};
        addr1  = {b_reg, a_reg};
        rd0_en = cmd.scan_read || cmd.assoc_read1 || cmd.assoc_read2;
        rd1_en = cmd.scan_read || cmd.assoc_read1;
        if (cmd.assoc_read1) begin
            addr0 = {b_reg, c_reg};
            addr1 = {ab_reg, c_reg};
        end else if (cmd.assoc_read2) begin
            addr0 = {a_reg, rd0_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_entry) begin
            table_mem[{lr_reg, lc_reg}] <= entry;
        end
        if (rd0_en) begin
            rd0_reg <= table_mem[addr0];
        end
        if (rd1_en) begin
            rd1_reg <= table_mem[addr1];
        end
        if (cmd.ab_read) begin
            ab_reg <= table_mem[addr0];
        end
    end

    always_comb begin
        sts.load_last  = load_last;
        sts.scan_last  = a_last && b_last;
        sts.c_last     = c_last;
        sts.assoc_last = (a_last && b_last && c_last) || (rd0_reg != rd1_reg);
        sts.assoc_skip = bad_reg;
    end

    // Row a is seen through rd0, column a through rd1.
    logic rows_reg, cols_reg, comm_reg, assoc_reg, left_reg, right_reg, two_reg;
    logic rowid_reg, colid_reg;
    mask_t row_mask_reg, col_mask_reg;
    mask_t row_seen, col_seen;
    logic first, rowid_run, colid_run;
    always_comb begin
        first     = (b_reg == '0);
        row_seen  = first ? '0 : row_mask_reg;
        col_seen  = first ? '0 : col_mask_reg;
        rowid_run = (first || rowid_reg) && (rd0_reg == b_reg);
        colid_run = (first || colid_reg) && (rd1_reg == b_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_eval) begin
            a_reg <= '0; b_reg <= '0; c_reg <= '0;
            rows_reg <= 1'b1; cols_reg <= 1'b1; comm_reg <= 1'b1;
            assoc_reg <= 1'b1; left_reg <= 1'b0; right_reg <= 1'b0;
            two_reg <= 1'b0;
        end else if (cmd.scan_check) begin
            if (row_seen[rd0_reg]) rows_reg <= 1'b0;
            if (col_seen[rd1_reg]) cols_reg <= 1'b0;
            if (rd0_reg != rd1_reg) comm_reg <= 1'b0;
            row_mask_reg <= row_seen | (mask_t'(1) << rd0_reg);
            col_mask_reg <= col_seen | (mask_t'(1) << rd1_reg);
            rowid_reg    <= rowid_run;
            colid_reg    <= colid_run;
            if (b_last) begin
                if (rowid_run) left_reg <= 1'b1;
                if (colid_run) right_reg <= 1'b1;
                if (rowid_run && colid_run) two_reg <= 1'b1;
                b_reg <= '0;
                a_reg <= a_last ? '0 : a_reg + IW'(1);
            end else begin
                b_reg <= b_reg + IW'(1);
            end
        end else if (cmd.assoc_check) begin
            if (rd1_reg != rd0_reg) assoc_reg <= 1'b0;
            if (c_last) begin
                c_reg <= '0;
                if (b_last) begin
                    b_reg <= '0;
                    a_reg <= a_reg + IW'(1);
                end else begin
                    b_reg <= b_reg + IW'(1);
                end
            end else begin
                c_reg <= c_reg + IW'(1);
            end
        end
    end

    logic [8:0] flags_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (cmd.load_result) begin
            flags_reg <= {bad_reg, right_reg, left_reg, two_reg, comm_reg,
                          assoc_reg && !bad_reg, rows_reg && cols_reg, cols_reg, rows_reg};
        end
    end
    assign flags = flags_reg;
endmodule

// File: hw/rtl/cayley_table_property_check.sv
// Channel   Direction  Content
// s_        in         one table entry per item, row-major
// cfg_      in         order register, always ready
// m_        out        one item of nine flags per completed table
// While loading, s_ready is high and an entry is taken whenever s_valid is high. After the n*n-th entry s_ready
// drops and the table is evaluated: first the row, column, commutativity and identity scan,
// then, when no bad entry was seen, associativity for each row and column pair, ending early
// at the first failing triple. The table store gives two registered reads a cycle. Reset is
// synchronous and active low; a stalled result holds the block before the next load until
// m_ready.
module cayley_table_property_check
    import ctpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_entry_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_rows_distinct,
    output logic       m_columns_distinct,
    output logic       m_latin_square,
    output logic       m_associative,
    output logic       m_commutative,
    output logic       m_two_sided_identity,
    output logic       m_left_identity,
    output logic       m_right_identity,
    output logic       m_bad_entry
);
    ctpc_cmd_t cmd;
    ctpc_sts_t sts;
    logic [8:0] flags;
    logic m_valid_reg;
    logic cfg_write;

    // A register write is taken at once and restarts loading.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    ctpc_ctrl u_ctrl (
        .aclk, .aresetn, .cfg_write, .s_valid, .s_ready,
        .res_free(!m_valid_reg || m_ready), .sts, .cmd
    );

    ctpc_dp u_dp (
        .aclk, .aresetn, .cfg_write, .cfg_order(cfg_data),
        .entry(s_entry_value), .cmd, .sts, .flags
    );

    // The result register holds one item until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_rows_distinct      = flags[0];
    assign m_columns_distinct   = flags[1];
    assign m_latin_square       = flags[2];
    assign m_associative        = flags[3];
    assign m_commutative        = flags[4];
    assign m_two_sided_identity = flags[5];
    assign m_left_identity      = flags[6];
    assign m_right_identity     = flags[7];
    assign m_bad_entry          = flags[8];
endmodule

// File: hw/rtl/ctpc_checker.sv
`include "cayley_table_property_check_assert.svh"
module ctpc_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_rows_distinct,
    input logic m_columns_distinct,
    input logic m_latin_square,
    input logic m_associative,
    input logic m_bad_entry
);
    `CTPC_ASSERT_IMP(a_latin, aclk, aresetn, m_valid, m_latin_square == (m_rows_distinct && m_columns_distinct))
    `CTPC_ASSERT_IMP(a_bad_assoc, aclk, aresetn, m_valid && m_bad_entry, !m_associative)
    `CTPC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule

bind cayley_table_property_check ctpc_checker u_ctpc_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_rows_distinct, .m_columns_distinct,
    .m_latin_square, .m_associative, .m_bad_entry
);

// File: tb/sv/cayley_table_property_check_checker.sv
`timescale 1ns / 1ps

module cayley_table_property_check_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [4:0] cfg_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [3:0] s_entry_value,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_rows_distinct,
    input  logic       m_columns_distinct,
    input  logic       m_latin_square,
    input  logic       m_associative,
    input  logic       m_commutative,
    input  logic       m_two_sided_identity,
    input  logic       m_left_identity,
    input  logic       m_right_identity,
    input  logic       m_bad_entry,
    output int         flags_waiting,
    output int         fail_count
);
    localparam int MAX_ORDER = 16;

    logic [3:0] shadow_table [MAX_ORDER*MAX_ORDER];
    logic [4:0] order_reg;
    int         entries_taken;
    logic       bad_in_load;
    logic [8:0] expected_flags [$];

    string flag_names [9] = '{"bad_entry", "right_identity", "left_identity",
        "two_sided_identity", "commutative", "associative", "latin_square",
        "columns_distinct", "rows_distinct"};

    function automatic int order_in_use(logic [4:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_ORDER) return MAX_ORDER;
        return int'(raw);
    endfunction

    // Flags in port order, rows_distinct in the top bit.
    function automatic logic [8:0] table_flags(int n, logic bad);
        logic rows, cols, assoc, comm, two, left, right, rowid, colid;
        int lhs, rhs;
        rows = 1; cols = 1; comm = 1; assoc = !bad;
        two = 0; left = 0; right = 0;
        for (int a = 0; a < n; a++) begin
            for (int b = 0; b < n; b++) begin
                if (shadow_table[a*n+b] != shadow_table[b*n+a]) comm = 0;
                for (int c = b + 1; c < n; c++) begin
                    if (shadow_table[a*n+b] == shadow_table[a*n+c]) rows = 0;
                    if (shadow_table[b*n+a] == shadow_table[c*n+a]) cols = 0;
                end
            end
        end
        // All entries are below n when no bad entry was seen, so indexing is safe.
        if (assoc) begin
            for (int a = 0; a < n; a++)
                for (int b = 0; b < n; b++)
                    for (int c = 0; c < n; c++) begin
                        lhs = shadow_table[int'(shadow_table[a*n+b])*n + c];
                        rhs = shadow_table[a*n + int'(shadow_table[b*n+c])];
                        if (lhs != rhs) assoc = 0;
                    end
        end
        for (int a = 0; a < n; a++) begin
            rowid = 1; colid = 1;
            for (int b = 0; b < n; b++) begin
                if (shadow_table[a*n+b] != b) rowid = 0;
                if (shadow_table[b*n+a] != b) colid = 0;
            end
            if (rowid) left = 1;
            if (colid) right = 1;
            if (rowid && colid) two = 1;
        end
        return {rows, cols, rows && cols, assoc, comm, two, left, right, bad};
    endfunction

    always @(posedge aclk) begin
        logic [8:0] seen;
        logic [8:0] want;
        int n;
        logic bad_now;
        if (!aresetn) begin
            order_reg     <= 5'd16;
            entries_taken = 0;
            bad_in_load   = 0;
            expected_flags.delete();
            flags_waiting <= 0;
            fail_count    <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                order_reg     <= cfg_data;
                entries_taken = 0;
                bad_in_load   = 0;
            end else if (s_valid && s_ready) begin
                n = order_in_use(order_reg);
                shadow_table[entries_taken] = s_entry_value;
                bad_now = bad_in_load || (int'(s_entry_value) >= n);
                bad_in_load = bad_now;
                entries_taken++;
                if (entries_taken == n * n) begin
                    expected_flags.push_back(table_flags(n, bad_now));
                    entries_taken = 0;
                    bad_in_load   = 0;
                end
            end
            if (m_valid && m_ready) begin
                seen = {m_rows_distinct, m_columns_distinct, m_latin_square,
                        m_associative, m_commutative, m_two_sided_identity,
                        m_left_identity, m_right_identity, m_bad_entry};
                if (expected_flags.size() == 0) begin
                    $display("%0t: unexpected result item, flags %b", $time, seen);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_flags.pop_front();
                    if (seen != want) begin
                        for (int i = 0; i < 9; i++)
                            if (seen[i] != want[i])
                                $display("%0t: %s expected %0b actual %0b",
                                         $time, flag_names[i], want[i], seen[i]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            flags_waiting <= expected_flags.size();
        end
    end

endmodule

// File: tb/sv/tb_cayley_table_property_check.sv
`timescale 1ns / 1ps

module tb_cayley_table_property_check;
    import ctpc_pkg::*;

    // Table generators; each one produces a differently shaped operation.
    typedef enum int {
        GEN_RANDOM_IN_RANGE,
        GEN_CYCLIC_GROUP,
        GEN_LEFT_ZERO,
        GEN_RIGHT_ZERO,
        GEN_ANY_VALUE,
        GEN_GROUP_ONE_FLIP
    } table_gen_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [3:0] s_entry_value;
    logic       m_valid;
    logic       m_ready;
    logic       m_rows_distinct, m_columns_distinct, m_latin_square;
    logic       m_associative, m_commutative, m_two_sided_identity;
    logic       m_left_identity, m_right_identity, m_bad_entry;
    int         flags_waiting;
    int         fail_count;

    int         entries_sent;
    int         current_n;
    // When set, both sides run without gaps for a while.
    logic       no_gaps;

    cayley_table_property_check u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_entry_value        (s_entry_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_rows_distinct      (m_rows_distinct),
        .m_columns_distinct   (m_columns_distinct),
        .m_latin_square       (m_latin_square),
        .m_associative        (m_associative),
        .m_commutative        (m_commutative),
        .m_two_sided_identity (m_two_sided_identity),
        .m_left_identity      (m_left_identity),
        .m_right_identity     (m_right_identity),
        .m_bad_entry          (m_bad_entry)
    );

    cayley_table_property_check_checker u_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_entry_value        (s_entry_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_rows_distinct      (m_rows_distinct),
        .m_columns_distinct   (m_columns_distinct),
        .m_latin_square       (m_latin_square),
        .m_associative        (m_associative),
        .m_commutative        (m_commutative),
        .m_two_sided_identity (m_two_sided_identity),
        .m_left_identity      (m_left_identity),
        .m_right_identity     (m_right_identity),
        .m_bad_entry          (m_bad_entry),
        .flags_waiting        (flags_waiting),
        .fail_count           (fail_count)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic int draw_gap();
        if (no_gaps) return 0;
        return $urandom_range(0, 4);
    endfunction

    // The result side stalls on its own; a gap of zero keeps m_ready high
    // across back-to-back items without lowering and raising it in one step.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // A completed table keeps a result pending until the result side takes it;
    // once nothing is pending the block is back to loading entries.
    task automatic settle_block();
        while (flags_waiting != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Order register writes happen only with the block idle. A write also
    // discards a partially loaded table.
    task automatic write_order(logic [4:0] value);
        int gap;
        settle_block();
        gap = draw_gap();
        if (gap > 0) repeat (gap) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        current_n = (value == 0) ? 1 : (value > 16) ? 16 : int'(value);
    endtask

    task automatic send_entry(logic [3:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_entry_value <= value;
        do @(posedge aclk); while (!s_ready);
        entries_sent++;
    endtask

    // Once an item is accepted, valid drops unless the next one follows at once.
    task automatic idle_input();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [3:0] product_for(table_gen_t gen, int a, int b, int n,
                                               int flip_a, int flip_b);
        case (gen)
            GEN_RANDOM_IN_RANGE: return 4'($urandom_range(0, n - 1));
            GEN_CYCLIC_GROUP:    return 4'((a + b) % n);
            GEN_LEFT_ZERO:       return 4'(a);
            GEN_RIGHT_ZERO:      return 4'(b);
            GEN_ANY_VALUE:       return 4'($urandom_range(0, 15));
            default: begin
                if (a == flip_a && b == flip_b)
                    return 4'((a + b + $urandom_range(1, 15)) % 16);
                return 4'((a + b) % n);
            end
        endcase
    endfunction

    task automatic send_table(table_gen_t gen, int entries);
        int fa, fb;
        fa = $urandom_range(0, current_n - 1);
        fb = $urandom_range(0, current_n - 1);
        for (int k = 0; k < entries; k++)
            send_entry(product_for(gen, k / current_n, k % current_n, current_n, fa, fb));
    endtask

    initial begin
        int pick;
        int tables;
        logic [4:0] order_value;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 5'd0;
        s_valid       = 1'b0;
        s_entry_value = 4'd0;
        no_gaps       = 1'b0;
        entries_sent  = 0;
        current_n     = 16;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Order one: a clean one-element table, then a bad entry.
        write_order(5'd1);
        send_entry(4'd0);
        send_entry(4'd15);
        // Order zero behaves as order one.
        idle_input();
        write_order(5'd0);
        send_entry(4'd0);
        // Order two: group, complemented table, left-zero table, bad entries.
        idle_input();
        write_order(5'd2);
        send_table(GEN_CYCLIC_GROUP, 4);
        send_entry(4'd1); send_entry(4'd0); send_entry(4'd0); send_entry(4'd1);
        send_table(GEN_LEFT_ZERO, 4);
        send_entry(4'd3); send_entry(4'd15); send_entry(4'd0); send_entry(4'd0);
        // A half-loaded table is thrown away by the next register write.
        send_entry(4'd1); send_entry(4'd1);
        idle_input();
        write_order(5'd3);
        send_table(GEN_RIGHT_ZERO, 9);

        // Full-size tables, once with the largest raw value written.
        idle_input();
        write_order(5'd31);
        send_table(GEN_CYCLIC_GROUP, 256);
        idle_input();
        write_order(5'd16);
        send_table(GEN_GROUP_ONE_FLIP, 256);

        // Random part: mostly small orders so evaluation stays quick.
        while (entries_sent < 1150) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) order_value = 5'($urandom_range(1, 5));
            else if (pick < 78) order_value = 5'd0;
            else if (pick < 95) order_value = 5'($urandom_range(6, 9));
            else if (entries_sent < 900) order_value = 5'($urandom_range(16, 31));
            else order_value = 5'($urandom_range(10, 15));
            idle_input();
            no_gaps = ($urandom_range(0, 3) == 0);
            write_order(order_value);
            tables = (current_n <= 5) ? $urandom_range(2, 8) : 1;
            for (int t = 0; t < tables; t++) begin
                // Now and then hold off until every result has drained.
                if ($urandom_range(0, 4) == 0) begin
                    idle_input();
                    while (flags_waiting != 0) @(posedge aclk);
                end
                send_table(table_gen_t'($urandom_range(0, 5)), current_n * current_n);
            end
            if ($urandom_range(0, 3) == 0)
                send_table(GEN_ANY_VALUE, $urandom_range(1, current_n * current_n - 1 + 1) - 1);
        end
        idle_input();

        settle_block();
        if (fail_count == 0) begin
            $display("cayley_table_property_check: match");
        end else begin
            $display("cayley_table_property_check: mismatch");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("cayley_table_property_check: mismatch");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ctpc_pkg.sv
hw/rtl/ctpc_ctrl.sv
hw/rtl/ctpc_dp.sv
hw/rtl/cayley_table_property_check.sv
hw/rtl/ctpc_checker.sv
tb/sv/cayley_table_property_check_checker.sv
tb/sv/tb_cayley_table_property_check.sv
